// ===== hdl/bfd_pkg.sv =====
// shared types and constants for the black frame detector
package bfd_pkg;

  localparam int LUMA_W    = 8;
  localparam int AMT_W     = 7;
  localparam int DIM_REG_W = 13;
  localparam int CNT_W     = 25;
  localparam int FRAME_W   = 32;
  localparam int PCT_W     = 7;
  localparam int NUM_W     = 32;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 13;
  localparam int QBITS     = 7;
  localparam int IDX_BITS  = 3;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMOUNT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd3;

  localparam logic [LUMA_W-1:0]    THRESHOLD_RST = 8'd32;
  localparam logic [AMT_W-1:0]     AMOUNT_RST    = 7'd98;
  localparam logic [DIM_REG_W-1:0] WIDTH_RST     = 13'd1920;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RST    = 13'd1080;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic pix;       // pixel item accepted
    logic start;     // accepted pixel closes the frame
    logic check;     // overflow / zero-denominator check
    logic step;      // one quotient bit
    logic load_out;  // move finished result into output register
  } bfd_cmd_t;

  typedef struct packed {
    logic out_free;
  } bfd_status_t;

endpackage

// ===== hdl/black_frame_detector.sv =====
// top level of the black frame detector
//
//  channel   signals                                   direction
//  s_*       tvalid tready tdata tuser tlast           in: luma samples
//  m_*       tvalid tready tdata tuser                 out: one item per frame
//  cfg_*     we addr data                              in: register writes
//
// pixel items are taken one per cycle; the item with tlast closes the frame
// after a frame end the input stalls for the overflow check, the bit-serial quotient
// of count*100 / (width*height) and the hand-off
// the hand-off cycle waits further while the previous result is still unread
// the output register holds a result while the next frame's pixels stream in
// rst is synchronous, clears count and frame numbers and loads register defaults
module black_frame_detector #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // luma[7:0]
  input  logic                          s_tuser,  // key_frame
  input  logic                          s_tlast,  // end_of_frame
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // frame_number[31:0], black_percent[38:32], last_key_number[70:39], zero[71]
  output logic [71:0]                   m_tdata,
  output logic                          m_tuser,  // is_black
  input  logic                          cfg_we,
  input  logic [bfd_pkg::IDX_W-1:0]     cfg_addr,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_data
);

  bfd_pkg::bfd_cmd_t              cmd;
  bfd_pkg::bfd_status_t           st;
  logic [bfd_pkg::FRAME_W-1:0]    frame_number, last_key_number;
  logic [bfd_pkg::PCT_W-1:0]      black_percent;

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bfd_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .luma            (s_tdata),
    .key_frame       (s_tuser),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .frame_number    (frame_number),
    .black_percent   (black_percent),
    .is_black        (m_tuser),
    .last_key_number (last_key_number)
  );

  assign m_tdata = {1'b0, last_key_number, black_percent, frame_number};

endmodule

// ===== hdl/bfd_ctrl.sv =====
// controller state machine: pixel accept, division sequencing, result hand-off
module bfd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tlast,
  output logic                 s_tready,
  input  bfd_pkg::bfd_status_t st,
  output bfd_pkg::bfd_cmd_t    cmd
);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state, state_next;
  logic [bfd_pkg::IDX_BITS-1:0]  bit_idx, bit_idx_next;

  assign s_tready = (state == S_RUN);

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd          = '0;
    cmd.pix      = s_tvalid && s_tready;
    cmd.start    = cmd.pix && s_tlast;
    case (state)
      S_RUN: begin
        if (cmd.start) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.check    = 1'b1;
        bit_idx_next = bfd_pkg::IDX_BITS'(bfd_pkg::QBITS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (bit_idx == '0) begin
          state_next = S_DONE;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_RUN;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("result loaded while output register busy");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && bit_idx == '0) |=> (state == S_DONE))
    else $error("division did not finish after last quotient bit");

  a_start_checks: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_CHK && !s_tready))
    else $error("frame end did not start the percentage check");

endmodule

// ===== hdl/bfd_datapath.sv =====
// datapath: config registers, black count, frame numbers, divider, output register
module bfd_datapath #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfd_pkg::bfd_cmd_t             cmd,
  output bfd_pkg::bfd_status_t          st,
  input  logic                          cfg_we,
  input  logic [bfd_pkg::IDX_W-1:0]     cfg_addr,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_data,
  input  logic [bfd_pkg::LUMA_W-1:0]    luma,
  input  logic                          key_frame,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [bfd_pkg::FRAME_W-1:0]   frame_number,
  output logic [bfd_pkg::PCT_W-1:0]     black_percent,
  output logic                          is_black,
  output logic [bfd_pkg::FRAME_W-1:0]   last_key_number
);

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (DW > bfd_pkg::DIM_REG_W) ? DW : bfd_pkg::DIM_REG_W;
  localparam int DEN_W = 2 * CW;
  localparam int SH_W  = (DEN_W + bfd_pkg::QBITS > bfd_pkg::NUM_W) ?
                         DEN_W + bfd_pkg::QBITS : bfd_pkg::NUM_W;

  logic [bfd_pkg::LUMA_W-1:0]    black_threshold;
  logic [bfd_pkg::AMT_W-1:0]     black_amount;
  logic [bfd_pkg::DIM_REG_W-1:0] frame_width;
  logic [bfd_pkg::DIM_REG_W-1:0] frame_height;

  logic [bfd_pkg::CNT_W-1:0]     black_count, count_final;
  logic [bfd_pkg::FRAME_W-1:0]   frame_counter, last_key_frame, frame_held;
  logic [CW-1:0]                 w_ext, h_ext, w_clamp, h_clamp;
  logic [DEN_W-1:0]              den, den_next;
  logic [bfd_pkg::NUM_W-1:0]     num;
  logic [SH_W-1:0]               rem, dsh;
  logic                          sat, ge;
  logic [bfd_pkg::QBITS-1:0]     quo;
  logic [bfd_pkg::PCT_W-1:0]     pct_final;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      black_threshold <= bfd_pkg::THRESHOLD_RST;
      black_amount    <= bfd_pkg::AMOUNT_RST;
      frame_width     <= bfd_pkg::WIDTH_RST;
      frame_height    <= bfd_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bfd_pkg::REG_THRESHOLD: black_threshold <= cfg_data[bfd_pkg::LUMA_W-1:0];
        bfd_pkg::REG_AMOUNT:    black_amount    <= cfg_data[bfd_pkg::AMT_W-1:0];
        bfd_pkg::REG_WIDTH:     frame_width     <= cfg_data[bfd_pkg::DIM_REG_W-1:0];
        bfd_pkg::REG_HEIGHT:    frame_height    <= cfg_data[bfd_pkg::DIM_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturating count including the current pixel
  assign count_final = black_count +
      bfd_pkg::CNT_W'((luma < black_threshold) && (black_count != '1));

  assign w_ext    = CW'(frame_width);
  assign h_ext    = CW'(frame_height);
  assign w_clamp  = (w_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : w_ext;
  assign h_clamp  = (h_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : h_ext;
  assign den_next = DEN_W'(w_clamp) * DEN_W'(h_clamp);
  assign num      = bfd_pkg::NUM_W'(count_final) * bfd_pkg::NUM_W'(bfd_pkg::PCT_FULL);

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      black_count    <= '0;
      frame_counter  <= '0;
      last_key_frame <= '0;
    end else if (cmd.pix) begin
      if (cmd.start) begin
        black_count   <= '0;
        frame_counter <= frame_counter + 1'b1;
        if (key_frame) begin
          last_key_frame <= frame_counter;
        end
      end else begin
        black_count <= count_final;
      end
    end
  end

  // restoring division of count*100 by width*height, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem        <= SH_W'(num);
      den        <= den_next;
      frame_held <= frame_counter;
    end else if (cmd.check) begin
      // quotient of 128 or more, or empty frame size, means full percentage
      sat <= (den == '0) || (rem >= (SH_W'(den) << bfd_pkg::QBITS));
      dsh <= SH_W'(den) << (bfd_pkg::QBITS - 1);
      quo <= '0;
    end else if (cmd.step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[bfd_pkg::QBITS-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  assign pct_final = (sat || (quo > bfd_pkg::PCT_FULL)) ? bfd_pkg::PCT_FULL : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_number    <= frame_held;
      black_percent   <= pct_final;
      is_black        <= (pct_final >= black_amount);
      last_key_number <= last_key_frame;
    end
  end

  assign st.out_free = !m_tvalid || m_tready;

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (black_percent <= bfd_pkg::PCT_FULL))
    else $error("black percentage above 100");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (black_count == '0))
    else $error("black count not cleared at frame end");

endmodule

// ===== dv/tb_black_frame_detector.sv =====
// testbench for black_frame_detector: frame-level prediction and in-order result checks
`timescale 1ns / 100ps

module tb_black_frame_detector;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          SETTLE       = 16;
  localparam int          RANDOM_ITEMS = 430;
  localparam logic [24:0] COUNT_SAT    = 25'h1FFFFFF;
  localparam logic [12:0] DIM_CLAMP    = 13'(4096);

  typedef struct {
    logic [31:0] frame_no;
    logic [6:0]  pct;
    logic        black;
    logic [31:0] key_no;
  } frame_verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       s_tlast = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [71:0]                m_tdata;
  logic                       m_tuser;
  logic                       cfg_we = 1'b0;
  logic [bfd_pkg::IDX_W-1:0]  cfg_addr = '0;
  logic [bfd_pkg::CFG_W-1:0]  cfg_data = '0;

  // mirror of the block's registers and frame state
  logic [7:0]        thr_reg;
  logic [6:0]        amt_reg;
  logic [12:0]       width_reg;
  logic [12:0]       height_reg;
  logic [24:0]       black_cnt;
  logic [31:0]       frame_cnt;
  logic [31:0]       key_frame_no;

  frame_verdict_t    pending_verdicts[$];
  frame_verdict_t    want;
  int                errors = 0;
  int                cycles = 0;
  int                pixels_sent = 0;
  bit                jitter = 1'b1;

  black_frame_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= !jitter || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[31:0] !== want.frame_no) begin
          $display("%0t: frame_number expected %0d actual %0d",
                   $time, want.frame_no, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[38:32] !== want.pct) begin
          $display("%0t: black_percent (frame %0d) expected %0d actual %0d",
                   $time, want.frame_no, want.pct, m_tdata[38:32]);
          errors++;
        end
        if (m_tuser !== want.black) begin
          $display("%0t: is_black (frame %0d) expected %b actual %b",
                   $time, want.frame_no, want.black, m_tuser);
          errors++;
        end
        if (m_tdata[70:39] !== want.key_no) begin
          $display("%0t: last_key_number (frame %0d) expected %0d actual %0d",
                   $time, want.frame_no, want.key_no, m_tdata[70:39]);
          errors++;
        end
      end
    end
  end

  // count a black pixel and, at a frame end, work out the frame's verdict
  task automatic predict_pixel(input logic [7:0] luma, input logic key, input logic eof);
    frame_verdict_t v;
    logic [63:0]    den;
    logic [63:0]    q;
    if (luma < thr_reg && black_cnt != COUNT_SAT) black_cnt++;
    if (eof) begin
      if (key) key_frame_no = frame_cnt;
      den = 64'(width_reg > DIM_CLAMP ? DIM_CLAMP : width_reg) *
            64'(height_reg > DIM_CLAMP ? DIM_CLAMP : height_reg);
      if (den == 0) begin
        v.pct = bfd_pkg::PCT_FULL;
      end else begin
        q = (64'(black_cnt) * 64'd100) / den;
        v.pct = (q > 64'd100) ? bfd_pkg::PCT_FULL : q[6:0];
      end
      v.frame_no = frame_cnt;
      v.black = ({1'b0, v.pct} >= {1'b0, amt_reg});
      v.key_no = key_frame_no;
      pending_verdicts.push_back(v);
      frame_cnt++;
      black_cnt = '0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] luma, input logic key, input logic eof);
    @(negedge clk);
    if (jitter && $urandom_range(99) < 30) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = luma;
    s_tuser = key;
    s_tlast = eof;
    do @(posedge clk); while (!s_tready);
    predict_pixel(luma, key, eof);
    pixels_sent++;
  endtask

  // stop sending and let every expected result come back
  task automatic drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bfd_pkg::IDX_W-1:0] idx,
                           input logic [bfd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bfd_pkg::REG_THRESHOLD: thr_reg = val[7:0];
      bfd_pkg::REG_AMOUNT:    amt_reg = val[6:0];
      bfd_pkg::REG_WIDTH:     width_reg = val[12:0];
      bfd_pkg::REG_HEIGHT:    height_reg = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [7:0] thr, input logic [6:0] amt,
                         input logic [12:0] w, input logic [12:0] h);
    drain();
    write_reg(bfd_pkg::REG_THRESHOLD, bfd_pkg::CFG_W'(thr));
    write_reg(bfd_pkg::REG_AMOUNT, bfd_pkg::CFG_W'(amt));
    write_reg(bfd_pkg::REG_WIDTH, w);
    write_reg(bfd_pkg::REG_HEIGHT, h);
  endtask

  // reset values, threshold boundary, keyframe tracking
  task automatic test_reset_defaults;
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd31, 1'b0, 1'b0);
    send_pixel(8'd32, 1'b1, 1'b1);
    send_pixel(8'd255, 1'b0, 1'b1);
  endtask

  task automatic test_register_extremes;
    // 1x1 frames: one black pixel is 100 percent, longer frames saturate
    set_all(8'd255, 7'd0, 13'd1, 13'd1);
    send_pixel(8'd255, 1'b1, 1'b1);
    send_pixel(8'd254, 1'b0, 1'b1);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b1);
    // threshold zero never counts
    set_all(8'd0, 7'd100, 13'd1, 13'd1);
    send_pixel(8'd0, 1'b0, 1'b1);
    drain();
    write_reg(bfd_pkg::REG_THRESHOLD, bfd_pkg::CFG_W'(8'd255));
    send_pixel(8'd0, 1'b1, 1'b1);
    // amount above 100 never flags
    drain();
    write_reg(bfd_pkg::REG_AMOUNT, bfd_pkg::CFG_W'(7'd127));
    send_pixel(8'd0, 1'b0, 1'b1);
    // zero width gives a zero denominator
    drain();
    write_reg(bfd_pkg::REG_WIDTH, 13'd0);
    send_pixel(8'd128, 1'b0, 1'b1);
    // oversized dimensions are clamped
    set_all(8'd200, 7'd1, 13'd8191, 13'd8191);
    send_pixel(8'd10, 1'b0, 1'b0);
    send_pixel(8'd10, 1'b1, 1'b1);
    set_all(8'd200, 7'd1, 13'd4096, 13'd0);
    send_pixel(8'd10, 1'b0, 1'b1);
    drain();
    write_reg(bfd_pkg::REG_HEIGHT, 13'd4096);
    send_pixel(8'd10, 1'b0, 1'b1);
  endtask

  function automatic logic [12:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 13'($urandom_range(1, 8));
    if (r < 85) return 13'd0;
    if (r < 90) return 13'($urandom_range(4096, 8191));
    return 13'($urandom_range(1, 8191));
  endfunction

  task automatic test_random_frames;
    int   phase;
    int   phase_end;
    int   n_pix;
    int   area;
    logic [7:0] luma;
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS + 20) begin
      set_all(8'($urandom_range(255)),
              ($urandom_range(9) == 0) ? 7'($urandom_range(101, 127))
                                       : 7'($urandom_range(0, 100)),
              pick_dim(), pick_dim());
      // one long stretch with both sides running flat out
      jitter = (phase != 2);
      phase_end = pixels_sent + 60;
      while (pixels_sent < phase_end) begin
        area = int'(width_reg) * int'(height_reg);
        if (area < 1 || area > 24) area = 24;
        n_pix = $urandom_range(1, area + area / 2);
        for (int i = 0; i < n_pix; i++) begin
          // lean toward dark pixels so high percentages occur
          if ($urandom_range(99) < 55 && thr_reg != 0) luma = 8'($urandom_range(0, thr_reg - 1));
          else luma = 8'($urandom_range(255));
          send_pixel(luma, 1'($urandom_range(1)), i == n_pix - 1);
        end
      end
      phase++;
    end
    jitter = 1'b1;
  endtask

  initial begin
    thr_reg = bfd_pkg::THRESHOLD_RST;
    amt_reg = bfd_pkg::AMOUNT_RST;
    width_reg = bfd_pkg::WIDTH_RST;
    height_reg = bfd_pkg::HEIGHT_RST;
    black_cnt = '0;
    frame_cnt = '0;
    key_frame_no = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_frames();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== black_frame_detector.f =====
hdl/bfd_pkg.sv
hdl/bfd_ctrl.sv
hdl/bfd_datapath.sv
hdl/black_frame_detector.sv
dv/tb_black_frame_detector.sv
